// ===== rtl/iblt_pkg.sv =====
// Shared types, constants and the byte-wise CRC step for the lookup table.
`default_nettype none
package iblt_pkg;

    localparam int MAX_HASHES_DEF      = 4;
    localparam int CELLS_PER_TABLE_DEF = 256;
    localparam int KEY_BYTES_DEF       = 8;
    localparam int VALUE_BYTES_DEF     = 8;
    localparam int QUEUE_DEPTH         = 2;

    localparam logic [31:0] CRC_POLY = 32'hEDB88320;

    typedef enum logic [1:0] {
        OP_INSERT = 2'd0,
        OP_DELETE = 2'd1,
        OP_GET    = 2'd2,
        OP_PEEL   = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        CFG_SEED   = 2'd0,
        CFG_HASHES = 2'd1,
        CFG_CELLS  = 2'd2
    } cfg_idx_t;

    // one CRC-32 byte step, reflected polynomial, eight dependent shifts
    function automatic logic [31:0] crc_byte(input logic [31:0] c_in, input logic [7:0] b);
        logic [31:0] c;
        c = c_in ^ {24'd0, b};
        for (int i = 0; i < 8; i++) begin
            c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        end
        return c;
    endfunction

endpackage
`default_nettype wire

// ===== rtl/iblt_front.sv =====
// Front end: accepts items, saturates lengths, masks padding, queues them.
`default_nettype none
module iblt_front
    import iblt_pkg::*;
#(
    parameter int KEY_BYTES   = KEY_BYTES_DEF,
    parameter int VALUE_BYTES = VALUE_BYTES_DEF
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic [1:0]  in_op,
    input  wire logic [63:0] in_key,
    input  wire logic [3:0]  in_klen,
    input  wire logic [63:0] in_val,
    input  wire logic [3:0]  in_vlen,
    output logic             q_valid,
    input  wire logic        q_ready,
    output logic [1:0]       q_op,
    output logic [63:0]      q_key,
    output logic [3:0]       q_klen,
    output logic [63:0]      q_val,
    output logic [3:0]       q_vlen
);

    localparam logic [3:0] KMAX = 4'(KEY_BYTES);
    localparam logic [3:0] VMAX = 4'(VALUE_BYTES);

    logic [1:0]  op_reg   [QUEUE_DEPTH];
    logic [63:0] key_reg  [QUEUE_DEPTH];
    logic [3:0]  klen_reg [QUEUE_DEPTH];
    logic [63:0] val_reg  [QUEUE_DEPTH];
    logic [3:0]  vlen_reg [QUEUE_DEPTH];
    logic        wptr_reg, rptr_reg;
    logic [1:0]  cnt_reg;

    logic [3:0]  klen_s, vlen_s;
    logic [63:0] key_m, val_m;
    logic        push, pop;

    always_comb
    begin
        klen_s = (in_klen > KMAX) ? KMAX : in_klen;
        vlen_s = (in_vlen > VMAX) ? VMAX : in_vlen;
        for (int i = 0; i < 8; i++) begin
            key_m[i*8 +: 8] = (4'(i) < klen_s) ? in_key[i*8 +: 8] : 8'd0;
            val_m[i*8 +: 8] = (4'(i) < vlen_s) ? in_val[i*8 +: 8] : 8'd0;
        end
    end

    assign in_ready = (cnt_reg != 2'(QUEUE_DEPTH));
    assign push     = in_valid && in_ready;
    assign q_valid  = (cnt_reg != 2'd0);
    assign pop      = q_valid && q_ready;

    assign q_op   = op_reg[rptr_reg];
    assign q_key  = key_reg[rptr_reg];
    assign q_klen = klen_reg[rptr_reg];
    assign q_val  = val_reg[rptr_reg];
    assign q_vlen = vlen_reg[rptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            op_reg[wptr_reg]   <= in_op;
            key_reg[wptr_reg]  <= key_m;
            klen_reg[wptr_reg] <= klen_s;
            val_reg[wptr_reg]  <= val_m;
            vlen_reg[wptr_reg] <= vlen_s;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg <= 1'b0;
            rptr_reg <= 1'b0;
            cnt_reg  <= 2'd0;
        end
        else
        begin
            if (push) wptr_reg <= ~wptr_reg;
            if (pop)  rptr_reg <= ~rptr_reg;
            cnt_reg <= cnt_reg + 2'(push) - 2'(pop);
        end
    end

`ifndef SYNTH
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= 2'(QUEUE_DEPTH)) else $error("queue overflow");
    a_push_count: assert property (@(posedge clk) disable iff (!rst_n)
        (push && !pop) |=> cnt_reg == $past(cnt_reg) + 2'd1) else $error("count slip");
    a_klen_sat: assert property (@(posedge clk) disable iff (!rst_n)
        q_valid |-> q_klen <= KMAX) else $error("key length unsaturated");
`endif

endmodule
`default_nettype wire

// ===== rtl/iblt_back.sv =====
// Back end: sequencer that hashes, updates, looks up and peels cells in memory.
`default_nettype none
module iblt_back
    import iblt_pkg::*;
#(
    parameter int MAX_HASHES      = MAX_HASHES_DEF,
    parameter int CELLS_PER_TABLE = CELLS_PER_TABLE_DEF
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic [31:0] seed,
    input  wire logic [2:0]  hash_count,
    input  wire logic [8:0]  cells_per_table,
    output logic             busy,
    input  wire logic        q_valid,
    output logic             q_ready,
    input  wire logic [1:0]  q_op,
    input  wire logic [63:0] q_key,
    input  wire logic [3:0]  q_klen,
    input  wire logic [63:0] q_val,
    input  wire logic [3:0]  q_vlen,
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic             status,
    output logic [63:0]      found_key,
    output logic [3:0]       found_key_length,
    output logic [63:0]      found_value,
    output logic [3:0]       found_value_length
);

    localparam int TW    = (MAX_HASHES > 1) ? $clog2(MAX_HASHES) : 1;
    localparam int CW    = $clog2(CELLS_PER_TABLE);
    localparam int AW    = TW + CW;
    // each table occupies a power-of-two slice so {table, cell} stays in range
    localparam int DEPTH = MAX_HASHES * (1 << CW);
    localparam int MW    = 16 + 64 + 64 + 4 + 4;

    typedef enum logic [10:0] {
        S_CLEAR = 11'b00000000001,
        S_IDLE  = 11'b00000000010,
        S_HASH  = 11'b00000000100,
        S_MOD   = 11'b00000001000,
        S_READ  = 11'b00000010000,
        S_WAIT  = 11'b00000100000,
        S_EXEC  = 11'b00001000000,
        S_SCANR = 11'b00010000000,
        S_SCANW = 11'b00100000000,
        S_SCANC = 11'b01000000000,
        S_OUT   = 11'b10000000000
    } state_t;

    state_t state_reg, state_next;

    // cell memory: {count, key xor, value xor, key length, value length}
    logic [MW-1:0] mem [DEPTH];
    logic [MW-1:0] rd_reg;
    logic [AW-1:0] raddr, waddr;
    logic [MW-1:0] wdata;
    logic          we;

    logic [AW:0]   clr_reg;
    logic [1:0]    op_reg;
    logic [63:0]   key_reg, val_reg;
    logic [3:0]    klen_reg, vlen_reg;
    logic [TW:0]   t_reg;
    logic [3:0]    byte_reg;
    logic [31:0]   crc_reg;
    logic [CW-1:0] cell_reg;
    logic [CW:0]   j_reg;
    logic [AW-1:0] addr_reg;
    logic          peel_reg;
    logic          st_reg;
    logic [63:0]   fk_reg, fv_reg;
    logic [3:0]    fkl_reg, fvl_reg;
    logic [31:0]   rem_reg;

    logic [TW:0]   n_tab;
    logic [CW:0]   m_cells;
    logic [15:0]   r_cnt;
    logic [63:0]   r_ks, r_vs;
    logic [3:0]    r_kl, r_vl;

    always_comb
    begin
        n_tab = (hash_count == 3'd0) ? (TW+1)'(1) :
                ({{(TW+1){1'b0}}, hash_count} > (TW+4)'(MAX_HASHES)) ?
                    (TW+1)'(MAX_HASHES) : (TW+1)'(hash_count);
        m_cells = (cells_per_table == 9'd0) ? (CW+1)'(1) :
                  ({{(CW+1){1'b0}}, cells_per_table} > (CW+10)'(CELLS_PER_TABLE)) ?
                      (CW+1)'(CELLS_PER_TABLE) : (CW+1)'(cells_per_table);
        {r_cnt, r_ks, r_vs, r_kl, r_vl} = rd_reg;
    end

    always_ff @(posedge clk)
    begin
        if (we) mem[waddr] <= wdata;
        rd_reg <= mem[raddr];
    end

    assign busy      = (state_reg != S_IDLE) || q_valid;
    assign q_ready   = (state_reg == S_IDLE);
    assign out_valid = (state_reg == S_OUT);
    assign status             = st_reg;
    assign found_key          = fk_reg;
    assign found_key_length   = fkl_reg;
    assign found_value        = fv_reg;
    assign found_value_length = fvl_reg;

    logic [AW-1:0] scan_addr;
    assign scan_addr = {t_reg[TW-1:0], j_reg[CW-1:0]};
    assign raddr = (state_reg == S_SCANR || state_reg == S_SCANW) ? scan_addr : addr_reg;

    logic cnt_upd_dec;
    logic [15:0] new_cnt;
    always_comb
    begin
        cnt_upd_dec = (op_reg != OP_INSERT);
        new_cnt = cnt_upd_dec ? r_cnt - 16'd1 : r_cnt + 16'd1;
        we    = 1'b0;
        waddr = addr_reg;
        wdata = {new_cnt, r_ks ^ key_reg, r_vs ^ val_reg,
                 (r_kl < klen_reg) ? klen_reg : r_kl,
                 (r_vl < vlen_reg) ? vlen_reg : r_vl};
        if (state_reg == S_CLEAR)
        begin
            we    = 1'b1;
            waddr = clr_reg[AW-1:0];
            wdata = '0;
        end
        else if (state_reg == S_EXEC && op_reg != OP_GET)
        begin
            we = 1'b1;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_CLEAR: if (clr_reg == (AW+1)'(DEPTH - 1)) state_next = S_IDLE;
            S_IDLE:  if (q_valid) state_next = (q_op == OP_PEEL) ? S_SCANR : S_HASH;
            S_HASH:  if (byte_reg >= klen_reg) state_next = S_MOD;
            S_MOD:   if (rem_reg < {{(31-CW){1'b0}}, m_cells}) state_next = S_READ;
            S_READ:  state_next = S_WAIT;
            S_WAIT:  state_next = S_EXEC;
            S_EXEC:
            begin
                if (op_reg == OP_GET)
                    state_next = (r_cnt == 16'd0 || r_cnt == 16'd1 ||
                                  t_reg + 1'b1 >= n_tab) ? S_OUT : S_HASH;
                else
                    state_next = (t_reg + 1'b1 >= n_tab) ? S_OUT : S_HASH;
            end
            S_SCANR: state_next = S_SCANW;
            S_SCANW: state_next = S_SCANC;
            S_SCANC:
            begin
                if (r_cnt == 16'd1) state_next = S_HASH;
                else if (j_reg + 1'b1 >= m_cells && t_reg + 1'b1 >= n_tab)
                    state_next = S_OUT;
                else state_next = S_SCANR;
            end
            S_OUT:   if (out_ready) state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
            clr_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == S_CLEAR) clr_reg <= clr_reg + 1'b1;
        end
    end

    // the modulus: subtract shifted copies of m_cells, one step per cycle,
    // skipping shifts that would overflow 32 bits
    logic [4:0] sh_reg;
    logic [31:0] sub;
    assign sub = {{(31-CW){1'b0}}, m_cells} << sh_reg;

    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            S_IDLE:
            begin
                op_reg   <= q_op;
                key_reg  <= q_key;
                klen_reg <= q_klen;
                val_reg  <= q_val;
                vlen_reg <= q_vlen;
                t_reg    <= '0;
                j_reg    <= '0;
                byte_reg <= '0;
                peel_reg <= 1'b0;
                st_reg   <= (q_op == OP_GET || q_op == OP_PEEL);
                fk_reg   <= '0;
                fkl_reg  <= '0;
                fv_reg   <= '0;
                fvl_reg  <= '0;
                crc_reg  <= ~seed;
            end
            S_HASH:
            begin
                if (byte_reg < klen_reg)
                begin
                    crc_reg  <= crc_byte(crc_reg, key_reg[byte_reg[2:0]*8 +: 8]);
                    byte_reg <= byte_reg + 4'd1;
                end
                else
                begin
                    rem_reg <= ~crc_reg;
                    sh_reg  <= 5'd31;
                end
            end
            S_MOD:
            begin
                if (rem_reg >= sub && (sub >> sh_reg) == {{(31-CW){1'b0}}, m_cells})
                    rem_reg <= rem_reg - sub;
                if (sh_reg != 5'd0) sh_reg <= sh_reg - 5'd1;
                addr_reg <= {t_reg[TW-1:0], rem_reg[CW-1:0]};
            end
            S_EXEC:
            begin
                if (op_reg == OP_GET && r_cnt == 16'd1 &&
                    r_kl == klen_reg && r_ks == key_reg)
                begin
                    st_reg  <= 1'b0;
                    fv_reg  <= r_vs;
                    fvl_reg <= r_vl;
                end
                t_reg    <= t_reg + 1'b1;
                byte_reg <= '0;
                crc_reg  <= ~(seed + {{(31-TW){1'b0}}, t_reg} + 32'd1);
            end
            S_SCANC:
            begin
                if (r_cnt == 16'd1)
                begin
                    st_reg   <= 1'b0;
                    fk_reg   <= r_ks;
                    fkl_reg  <= r_kl;
                    fv_reg   <= r_vs;
                    fvl_reg  <= r_vl;
                    key_reg  <= r_ks;
                    klen_reg <= r_kl;
                    val_reg  <= r_vs;
                    vlen_reg <= r_vl;
                    op_reg   <= OP_DELETE;
                    peel_reg <= 1'b1;
                    t_reg    <= '0;
                    byte_reg <= '0;
                    crc_reg  <= ~seed;
                end
                else if (j_reg + 1'b1 >= m_cells)
                begin
                    j_reg <= '0;
                    t_reg <= t_reg + 1'b1;
                end
                else j_reg <= j_reg + 1'b1;
            end
            default: ;
        endcase
    end

`ifndef SYNTH
    a_peel_is_delete: assert property (@(posedge clk) disable iff (!rst_n)
        (peel_reg && state_reg == S_EXEC) |-> op_reg == OP_DELETE) else $error("peel op");
    a_idle_ready: assert property (@(posedge clk) disable iff (!rst_n)
        q_ready |-> !out_valid) else $error("ready while holding result");
    a_mod_range: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_READ |-> addr_reg[CW-1:0] < m_cells) else $error("cell out of range");
    a_one_hot: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot(state_reg)) else $error("state");
`endif

endmodule
`default_nettype wire

// ===== rtl/invertible_bloom_lookup_table.sv =====
// Top level: configuration registers, front queue and back-end sequencer.
// Invertible Bloom lookup table. After reset the cell memory is cleared, one cell a cycle,
// all MAX_HASHES times CELLS_PER_TABLE (rounded up to a power of two) cells, 1024 by
// default, before the first item is taken. Insert, delete and get hash the key per table
// at one byte a cycle, reduce the CRC modulo the cell count by shift and subtract, then
// read-modify-write one cell through the read, wait and execute states. The result waits
// for out_ready. Get stops at the first table with a count of zero or one. Peel scans the
// cells one by one through the scan states and then deletes the pair as above. Items queue
// two deep in front of the sequencer. The user must write configuration only while no item
// is in flight; the block itself does not enforce it.
`default_nettype none
module invertible_bloom_lookup_table
    import iblt_pkg::*;
#(
    parameter int MAX_HASHES      = MAX_HASHES_DEF,
    parameter int CELLS_PER_TABLE = CELLS_PER_TABLE_DEF,
    parameter int KEY_BYTES       = KEY_BYTES_DEF,
    parameter int VALUE_BYTES     = VALUE_BYTES_DEF
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [31:0] cfg_data,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic [1:0]  opcode,
    input  wire logic [63:0] key,
    input  wire logic [3:0]  key_length,
    input  wire logic [63:0] value,
    input  wire logic [3:0]  value_length,
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic             status,
    output logic [63:0]      found_key,
    output logic [3:0]       found_key_length,
    output logic [63:0]      found_value,
    output logic [3:0]       found_value_length
);

    logic [31:0] seed_reg;
    logic [2:0]  hc_reg;
    logic [8:0]  cpt_reg;
    logic        busy;

    logic        q_valid, q_ready;
    logic [1:0]  q_op;
    logic [63:0] q_key, q_val;
    logic [3:0]  q_klen, q_vlen;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seed_reg <= '0;
            hc_reg   <= 3'd3;
            cpt_reg  <= 9'd256;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                CFG_SEED:   seed_reg <= cfg_data;
                CFG_HASHES: hc_reg   <= cfg_data[2:0];
                CFG_CELLS:  cpt_reg  <= cfg_data[8:0];
                default: ;
            endcase
        end
    end

    iblt_front #(.KEY_BYTES(KEY_BYTES), .VALUE_BYTES(VALUE_BYTES)) u_front (
        .clk, .rst_n, .in_valid, .in_ready,
        .in_op(opcode), .in_key(key), .in_klen(key_length),
        .in_val(value), .in_vlen(value_length),
        .q_valid, .q_ready, .q_op, .q_key, .q_klen, .q_val, .q_vlen
    );

    iblt_back #(.MAX_HASHES(MAX_HASHES), .CELLS_PER_TABLE(CELLS_PER_TABLE)) u_back (
        .clk, .rst_n, .seed(seed_reg), .hash_count(hc_reg), .cells_per_table(cpt_reg),
        .busy, .q_valid, .q_ready, .q_op, .q_key, .q_klen, .q_val, .q_vlen,
        .out_valid, .out_ready, .status, .found_key, .found_key_length,
        .found_value, .found_value_length
    );

`ifndef SYNTH
    a_cfg_idle: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_valid |-> !busy) else $error("cfg while busy");
    a_hc_reset: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rst_n) |-> hc_reg == 3'd3) else $error("reset value");
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> out_valid) else $error("result dropped");
`endif

endmodule
`default_nettype wire

// ===== tb/invertible_bloom_lookup_table_tb.sv =====
// Self-checking testbench for the invertible Bloom lookup table.
`timescale 1ns / 1ps
module invertible_bloom_lookup_table_tb;
    import iblt_pkg::*;

    localparam int NT = 4;
    localparam int NC = 256;
    localparam int LIMIT = 200000;

    typedef struct packed {
        logic        status;
        logic [63:0] fkey;
        logic [3:0]  fklen;
        logic [63:0] fval;
        logic [3:0]  fvlen;
    } answer_t;

    // table shadow and expected answers
    class iblt_scoreboard;
        logic [31:0] seed_r;
        logic [2:0]  hashes_r;
        logic [8:0]  cells_r;
        logic [15:0] cnt[NT*NC];
        logic [63:0] ksum[NT*NC];
        logic [63:0] vsum[NT*NC];
        logic [3:0]  klen_s[NT*NC];
        logic [3:0]  vlen_s[NT*NC];
        answer_t     pending[$];
        int          errors;

        function new();
            seed_r = 0;
            hashes_r = 3;
            cells_r = 256;
            errors = 0;
            for (int i = 0; i < NT*NC; i++)
            begin
                cnt[i] = 0; ksum[i] = 0; vsum[i] = 0; klen_s[i] = 0; vlen_s[i] = 0;
            end
        endfunction

        function void write_reg(cfg_idx_t idx, logic [31:0] d);
            case (idx)
                CFG_SEED:   seed_r = d;
                CFG_HASHES: hashes_r = d[2:0];
                CFG_CELLS:  cells_r = d[8:0];
                default: ;
            endcase
        endfunction

        function int n_tables();
            if (hashes_r == 0)
                return 1;
            return hashes_r > NT ? NT : hashes_r;
        endfunction

        function int n_cells();
            if (cells_r == 0)
                return 1;
            return cells_r > NC ? NC : cells_r;
        endfunction

        function int slot(int t, logic [63:0] k, int kl);
            logic [31:0] c;
            c = (seed_r + t) ^ 32'hFFFFFFFF;
            for (int i = 0; i < kl; i++)
            begin
                c ^= {24'd0, k[8*i +: 8]};
                for (int b = 0; b < 8; b++)
                    c = c[0] ? ((c >> 1) ^ 32'hEDB88320) : (c >> 1);
            end
            c ^= 32'hFFFFFFFF;
            return t * NC + int'(c % n_cells());
        endfunction

        function void update(bit add, logic [63:0] k, int kl, logic [63:0] v, int vl);
            int c;
            for (int t = 0; t < n_tables(); t++)
            begin
                c = slot(t, k, kl);
                cnt[c] = add ? cnt[c] + 16'd1 : cnt[c] - 16'd1;
                ksum[c] ^= k;
                vsum[c] ^= v;
                if (klen_s[c] < kl) klen_s[c] = 4'(kl);
                if (vlen_s[c] < vl) vlen_s[c] = 4'(vl);
            end
        endfunction

        function void note_item(op_t op, logic [63:0] k_in, logic [3:0] kl_in,
                                logic [63:0] v_in, logic [3:0] vl_in);
            int kl, vl, c;
            logic [63:0] k, v;
            answer_t a;
            bit done;
            kl = kl_in > 8 ? 8 : kl_in;
            vl = vl_in > 8 ? 8 : vl_in;
            k = kl >= 8 ? k_in : k_in & ((64'd1 << (8*kl)) - 1);
            v = vl >= 8 ? v_in : v_in & ((64'd1 << (8*vl)) - 1);
            a = '0;
            done = 0;
            case (op)
                OP_INSERT, OP_DELETE: update(op == OP_INSERT, k, kl, v, vl);
                OP_GET:
                begin
                    a.status = 1;
                    for (int t = 0; t < n_tables() && !done; t++)
                    begin
                        c = slot(t, k, kl);
                        if (cnt[c] == 0)
                            done = 1;
                        else if (cnt[c] == 1)
                        begin
                            done = 1;
                            if (klen_s[c] == kl && ksum[c] == k)
                            begin
                                a.status = 0; a.fval = vsum[c]; a.fvlen = vlen_s[c];
                            end
                        end
                    end
                end
                default:
                begin
                    a.status = 1;
                    for (int t = 0; t < n_tables() && !done; t++)
                        for (int j = 0; j < n_cells() && !done; j++)
                        begin
                            c = t * NC + j;
                            if (cnt[c] == 1)
                            begin
                                done = 1;
                                a = {1'b0, ksum[c], klen_s[c], vsum[c], vlen_s[c]};
                                update(0, a.fkey, a.fklen, a.fval, a.fvlen);
                            end
                        end
                end
            endcase
            pending.push_back(a);
        endfunction

        function void check(answer_t got);
            answer_t e;
            if (pending.size() == 0)
            begin
                $error("unexpected result item");
                errors++;
                return;
            end
            e = pending.pop_front();
            if (got.status !== e.status)
            begin
                $error("status exp %0h got %0h", e.status, got.status); errors++;
            end
            if (got.fkey !== e.fkey)
            begin
                $error("found_key exp %h got %h", e.fkey, got.fkey); errors++;
            end
            if (got.fklen !== e.fklen)
            begin
                $error("found_key_length exp %0d got %0d", e.fklen, got.fklen); errors++;
            end
            if (got.fval !== e.fval)
            begin
                $error("found_value exp %h got %h", e.fval, got.fval); errors++;
            end
            if (got.fvlen !== e.fvlen)
            begin
                $error("found_value_length exp %0d got %0d", e.fvlen, got.fvlen);
                errors++;
            end
        endfunction
    endclass

    logic clk = 0;
    logic rst_n = 0;
    logic cfg_valid = 0, cfg_ready;
    logic [1:0] cfg_index = 0;
    logic [31:0] cfg_data = 0;
    logic in_valid = 0, in_ready;
    logic [1:0] opcode = 0;
    logic [63:0] key = 0, value = 0;
    logic [3:0] key_length = 0, value_length = 0;
    logic out_valid, out_ready = 0;
    logic status;
    logic [63:0] found_key, found_value;
    logic [3:0] found_key_length, found_value_length;

    iblt_scoreboard sb;
    int idle_cycles = 0;
    logic [63:0] known_keys[8];
    logic [3:0]  known_klen[8];

    always #1 clk = ~clk;

    invertible_bloom_lookup_table u_dut (.*);

    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > LIMIT)
        begin
            $display("** invertible_bloom_lookup_table: FAILED **");
            $finish;
        end
        if (rst_n && out_valid && out_ready)
            sb.check({status, found_key, found_key_length, found_value, found_value_length});
    end

    // receiver stall pattern
    initial
    begin
        int mode;
        forever
        begin
            @(negedge clk);
            mode = ($urandom_range(0, 199) < 60) ? 0 : 1;
            repeat ($urandom_range(10, 60))
            begin
                out_ready <= (mode == 0) ? 1'b1 : ($urandom_range(0, 2) != 0);
                @(negedge clk);
            end
        end
    end

    task automatic wait_drained();
        while (sb.pending.size() != 0)
            @(negedge clk);
        repeat (300) @(negedge clk);
    endtask

    task automatic write_reg(cfg_idx_t idx, logic [31:0] d);
        cfg_valid <= 1; cfg_index <= idx; cfg_data <= d;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        sb.write_reg(idx, d);
        @(negedge clk);
        cfg_valid <= 0;
        @(negedge clk);
    endtask

    task automatic send(op_t op, logic [63:0] k, logic [3:0] kl, logic [63:0] v,
                        logic [3:0] vl);
        in_valid <= 1; opcode <= op; key <= k; key_length <= kl;
        value <= v; value_length <= vl;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        sb.note_item(op, k, kl, v, vl);
        @(negedge clk);
    endtask

    task automatic send_random(int n);
        int left, gap;
        op_t op;
        int pick;
        logic [63:0] k;
        logic [3:0] kl;
        left = n;
        while (left > 0)
        begin
            repeat ($urandom_range(1, 20))
            begin
                if (left == 0) break;
                pick = $urandom_range(0, 99);
                op = pick < 40 ? OP_INSERT : pick < 55 ? OP_DELETE :
                     pick < 80 ? OP_GET : OP_PEEL;
                pick = $urandom_range(0, 7);
                if ($urandom_range(0, 3) != 0)
                begin
                    k = known_keys[pick]; kl = known_klen[pick];
                end
                else
                begin
                    k = {$urandom, $urandom}; kl = $urandom_range(0, 15);
                end
                send(op, k, kl, {$urandom, $urandom}, $urandom_range(0, 15));
                left--;
            end
            gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 12);
            if (gap > 0)
            begin
                in_valid <= 0;
                repeat (gap) @(negedge clk);
            end
        end
        in_valid <= 0;
    endtask

    initial
    begin
        sb = new();
        repeat (4) @(negedge clk);
        rst_n = 1;

        send(OP_GET, 64'h1122, 2, 0, 0);
        send(OP_PEEL, 0, 0, 0, 0);
        send(OP_INSERT, 64'hFFFF_FFFF_FFFF_FFFF, 8, 64'hFFFF_FFFF_FFFF_FFFF, 8);
        send(OP_GET, 64'hFFFF_FFFF_FFFF_FFFF, 8, 0, 0);
        send(OP_INSERT, 64'hDEAD_BEEF_0000_0042, 15, 64'hABCD, 15);
        send(OP_GET, 64'h42, 1, 0, 0);
        send(OP_INSERT, 0, 0, 64'h5, 0);
        send(OP_GET, 0, 0, 0, 0);
        send(OP_DELETE, 64'h7777, 2, 64'h1, 1);
        send(OP_GET, 64'h7777, 2, 0, 0);
        send(OP_INSERT, 64'h7777, 2, 64'h1, 1);
        send(OP_PEEL, 0, 0, 0, 0);
        send(OP_PEEL, 0, 0, 0, 0);
        send(OP_PEEL, 0, 0, 0, 0);
        send(OP_PEEL, 0, 0, 0, 0);
        in_valid <= 0;
        wait_drained();

        foreach (known_keys[i])
        begin
            known_keys[i] = {$urandom, $urandom};
            known_klen[i] = $urandom_range(1, 8);
        end

        // geometry sweeps, store not cleared between
        for (int ph = 0; ph < 7; ph++)
        begin
            case (ph)
                0: begin write_reg(CFG_HASHES, 1); write_reg(CFG_CELLS, 1); end
                1: begin write_reg(CFG_HASHES, 0); write_reg(CFG_CELLS, 0); end
                2: begin write_reg(CFG_HASHES, 7); write_reg(CFG_CELLS, 511); end
                3: begin write_reg(CFG_SEED, 32'hFFFF_FFFF); write_reg(CFG_HASHES, 4);
                         write_reg(CFG_CELLS, 256); end
                4: begin write_reg(CFG_SEED, $urandom); write_reg(CFG_HASHES, 2);
                         write_reg(CFG_CELLS, 4); end
                5: begin write_reg(CFG_HASHES, $urandom_range(0, 7));
                         write_reg(CFG_CELLS, $urandom_range(0, 511)); end
                default: begin write_reg(CFG_SEED, 0); write_reg(CFG_HASHES, 3);
                         write_reg(CFG_CELLS, 16); end
            endcase
            // cells up to 256 make peel scans long, keep those phases short
            send_random((ph == 2 || ph == 3) ? 120 : 260);
            wait_drained();
        end

        if (sb.errors == 0)
            $display("** invertible_bloom_lookup_table: PASSED **");
        else
            $display("** invertible_bloom_lookup_table: FAILED **");
        $finish;
    end
endmodule
